// ----- hdl/swld_pkg.sv -----
// Package for the sync word length deframer.
// Holds the phase enum, result and sync word structs, and register codes.
// Depends on nothing; every other file imports it.
`default_nettype none

package swld_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int DROP_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Reset values of the sync word registers.
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h97;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h53;
  localparam logic [BYTE_W-1:0] SYNC_THIRD_RST  = 8'h71;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // Discard counts.
  localparam logic [DROP_W-1:0] DROP_NONE  = 2'd0;
  localparam logic [DROP_W-1:0] DROP_ONE   = 2'd1;
  localparam logic [DROP_W-1:0] DROP_TWO   = 2'd2;
  localparam logic [DROP_W-1:0] DROP_THREE = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ONE  = 3'd1,
    PH_TWO  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } sync_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload;
    logic              frame_end;
    logic [DROP_W-1:0] dropped;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/sync_word_length_deframer_top.sv -----
// Sync word length deframer, top level. Each accepted request passes through
// the input register and then the result register before its result appears.
// Throughput is one byte per cycle while the sink does not stall.
// Synchronous active-low reset empties both registers, returns to sync hunt
// and loads the sync word 0x97 0x53 0x71. Depends on swld_pkg and submodules.
`default_nettype none

module sync_word_length_deframer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Byte input channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [swld_pkg::BYTE_W-1:0]    in_rx_byte,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [swld_pkg::KIND_W-1:0]         out_kind,
  output logic [swld_pkg::BYTE_W-1:0]         out_payload,
  output logic                                out_frame_end,
  output logic [swld_pkg::DROP_W-1:0]         out_dropped,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [swld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swld_pkg::BYTE_W-1:0]    cfg_data
);
  import swld_pkg::*;

  // The pipeline is two registers deep. The input register holds a received
  // byte; the core consumes it, updates the phase and remaining count, and the
  // result lands in the result register in the same cycle. A new request is
  // accepted whenever the input register is empty or handing on its byte, so
  // while a result waits for the sink the input register can still take a byte.

  sync_cfg_t sync_r;
  logic              s1_valid, adv;
  logic [BYTE_W-1:0] s1_byte;
  result_t           result;

  // Configuration writes are always taken. An index past the last register
  // completes the handshake and changes nothing.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r.first  <= SYNC_FIRST_RST;
      sync_r.second <= SYNC_SECOND_RST;
      sync_r.third  <= SYNC_THIRD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_r.first  <= cfg_data;
        CFG_SYNC_SECOND: sync_r.second <= cfg_data;
        CFG_SYNC_THIRD:  sync_r.third  <= cfg_data;
        default: ;
      endcase
    end
  end

  swld_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  // The core advances its state only when the byte moves into the result
  // register, so a stalled sink never causes a byte to be counted twice.
  swld_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .rx_byte  (s1_byte),
    .sync_cfg (sync_r),
    .result   (result)
  );

  swld_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .result        (result),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_payload   (out_payload),
    .out_frame_end (out_frame_end),
    .out_dropped   (out_dropped)
  );

  // A frame end is only ever reported with a payload byte or an empty frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> (out_kind != KIND_NONE))
    else $error("frame end without frame content");

  // Frame content and discarded bytes never appear in the same result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_NONE) |-> (out_dropped == DROP_NONE))
    else $error("discard reported alongside frame content");

  // A consumed byte always leaves a valid result behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("consumed byte produced no result");

  // Payload bytes are zero unless the result carries a payload byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> (out_payload == '0))
    else $error("payload set on a non-payload result");

endmodule

`default_nettype wire

// ----- hdl/swld_in_stage.sv -----
// Input register of the deframer: holds one received byte until the core
// consumes it. Depends on swld_pkg.
`default_nettype none

module swld_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [swld_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                           in_stall,
  input  wire logic                      adv,
  output logic                           s1_valid,
  output logic [swld_pkg::BYTE_W-1:0]    s1_byte
);
  import swld_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              accept;

  // The register can take a new request in the same cycle it hands one on.
  assign in_stall = valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

// ----- hdl/swld_core.sv -----
// Deframing state machine: sync hunt, length capture and payload count.
// Produces one result per consumed byte. Depends on swld_pkg.
`default_nettype none

module swld_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire logic [swld_pkg::BYTE_W-1:0] rx_byte,
  input  wire swld_pkg::sync_cfg_t         sync_cfg,
  output swld_pkg::result_t                result
);
  import swld_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              eq_first, eq_second, eq_third, last_byte;

  assign eq_first  = (rx_byte == sync_cfg.first);
  assign eq_second = (rx_byte == sync_cfg.second);
  assign eq_third  = (rx_byte == sync_cfg.third);
  assign last_byte = (bytes_left_r <= BYTE_W'(1));

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    case (phase_r)
      PH_ONE: begin
        if (eq_second) begin
          phase_nxt = PH_TWO;
        end else if (eq_first) begin
          phase_nxt = PH_ONE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_TWO: begin
        if (eq_third) begin
          phase_nxt = PH_LEN;
        end else if ((sync_cfg.second == sync_cfg.first) && eq_second) begin
          phase_nxt = PH_TWO;
        end else if (eq_first) begin
          phase_nxt = PH_ONE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        bytes_left_nxt = rx_byte;
        if (rx_byte == '0) begin
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (last_byte) begin
          bytes_left_nxt = '0;
          phase_nxt      = PH_HUNT;
        end else begin
          bytes_left_nxt = bytes_left_r - BYTE_W'(1);
        end
      end
      default: begin
        phase_nxt = eq_first ? PH_ONE : PH_HUNT;
      end
    endcase
  end

  // Result for the byte being consumed.
  always_comb begin
    result           = '0;
    result.kind      = KIND_NONE;
    result.dropped   = DROP_NONE;
    case (phase_r)
      PH_ONE: begin
        if (eq_second) begin
          result.dropped = DROP_NONE;
        end else if (eq_first) begin
          result.dropped = DROP_ONE;
        end else begin
          result.dropped = DROP_TWO;
        end
      end
      PH_TWO: begin
        if (eq_third) begin
          result.dropped = DROP_NONE;
        end else if ((sync_cfg.second == sync_cfg.first) && eq_second) begin
          result.dropped = DROP_ONE;
        end else if (eq_first) begin
          result.dropped = DROP_TWO;
        end else begin
          result.dropped = DROP_THREE;
        end
      end
      PH_LEN: begin
        if (rx_byte == '0) begin
          result.kind      = KIND_EMPTY;
          result.frame_end = 1'b1;
        end
      end
      PH_DATA: begin
        result.kind      = KIND_DATA;
        result.payload   = rx_byte;
        result.frame_end = last_byte;
      end
      default: begin
        result.dropped = eq_first ? DROP_NONE : DROP_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_left_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/swld_out_stage.sv -----
// Result register of the deframer with its handshake toward the sink.
// Decides when the core may consume the held input byte. Depends on swld_pkg.
`default_nettype none

module swld_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  input  wire swld_pkg::result_t           result,
  output logic                             adv,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [swld_pkg::KIND_W-1:0]      out_kind,
  output logic [swld_pkg::BYTE_W-1:0]      out_payload,
  output logic                             out_frame_end,
  output logic [swld_pkg::DROP_W-1:0]      out_dropped
);
  import swld_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // The result register loads a held input byte whenever it is empty or being drained.
  assign adv = s1_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= result;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = res_r.kind;
  assign out_payload   = res_r.payload;
  assign out_frame_end = res_r.frame_end;
  assign out_dropped   = res_r.dropped;

endmodule

`default_nettype wire

// ----- tb/tb_sync_word_length_deframer_top.sv -----
// Self-checking testbench for the sync word length deframer top level.
// Drives bytes and sync word writes, predicts every result and compares it.
// Depends on swld_pkg and sync_word_length_deframer_top.
`default_nettype none

module tb_sync_word_length_deframer_top;
  import swld_pkg::*;

  // Index 3 has no register behind it. A write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // The slowest correct run is roughly 900 requests, each of which waits out
  // a long sender gap and a long result stall. This limit is several times that.
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BYTES  = 800;
  localparam int SETTING_COUNT = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_payload;
  logic                 out_frame_end;
  logic [DROP_W-1:0]    out_dropped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  sync_word_length_deframer_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_payload   (out_payload),
    .out_frame_end (out_frame_end),
    .out_dropped   (out_dropped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Our own copy of the deframer state and of the sync word registers.
  phase_t            hunt_phase;
  logic [BYTE_W-1:0] frame_left;
  sync_cfg_t         sync_word;

  // Results predicted for accepted requests, oldest first.
  result_t deframed_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_hold = 0;
  int stall_roll;
  int random_sent = 0;

  // While steady is set, neither side idles or stalls, so the block runs
  // back to back at full rate.
  bit steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // A hung handshake or a lost result would otherwise run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Predicts the one result that a received byte causes and advances the
  // phase. The length and payload bytes are never compared against the sync
  // word, and a broken sync keeps whatever can still start a new match.
  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] rx);
    result_t res;
    res = '0;
    res.kind = KIND_NONE;
    res.dropped = DROP_NONE;
    case (hunt_phase)
      PH_ONE: begin
        if (rx == sync_word.second) begin
          hunt_phase = PH_TWO;
        end else if (rx == sync_word.first) begin
          // The held byte goes, the new one takes its place.
          res.dropped = DROP_ONE;
        end else begin
          res.dropped = DROP_TWO;
          hunt_phase = PH_HUNT;
        end
      end
      PH_TWO: begin
        if (rx == sync_word.third) begin
          hunt_phase = PH_LEN;
        end else if (sync_word.second == sync_word.first && rx == sync_word.second) begin
          // With equal first and second bytes, the last two bytes still
          // form a valid start of the sync word.
          res.dropped = DROP_ONE;
        end else if (rx == sync_word.first) begin
          res.dropped = DROP_TWO;
          hunt_phase = PH_ONE;
        end else begin
          res.dropped = DROP_THREE;
          hunt_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (rx == '0) begin
          res.kind = KIND_EMPTY;
          res.frame_end = 1'b1;
          frame_left = '0;
          hunt_phase = PH_HUNT;
        end else begin
          frame_left = rx;
          hunt_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        res.kind = KIND_DATA;
        res.payload = rx;
        if (frame_left <= 8'd1) begin
          frame_left = '0;
          res.frame_end = 1'b1;
          hunt_phase = PH_HUNT;
        end else begin
          frame_left = frame_left - 8'd1;
        end
      end
      default: begin
        if (rx == sync_word.first) begin
          hunt_phase = PH_ONE;
        end else begin
          res.dropped = DROP_ONE;
          hunt_phase = PH_HUNT;
        end
      end
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100) begin
      $display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Result side: random stalls, mostly short runs with a few long ones.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(8, 40);
      end
    end
  end

  // Every result accepted at this edge is matched against the oldest
  // prediction. The values read here are the ones present before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (deframed_q.size() == 0) begin
        flag_mismatch("result with nothing pending, kind", out_kind, 0);
      end else begin
        result_t want;
        want = deframed_q.pop_front();
        if (out_kind !== want.kind) flag_mismatch("kind", out_kind, want.kind);
        if (out_payload !== want.payload) flag_mismatch("payload", out_payload, want.payload);
        if (out_frame_end !== want.frame_end) begin
          flag_mismatch("frame_end", out_frame_end, want.frame_end);
        end
        if (out_dropped !== want.dropped) flag_mismatch("dropped", out_dropped, want.dropped);
      end
    end
  end

  // Sender gap after a request: usually none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Sends one byte request and records its prediction once it is accepted.
  // Valid stays high into the next request when there is no gap.
  task automatic send_byte(input logic [BYTE_W-1:0] rx);
    int gap;
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframed_q.push_back(deframe_byte(rx));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_sync();
    send_byte(sync_word.first);
    send_byte(sync_word.second);
    send_byte(sync_word.third);
  endtask

  // Waits until every predicted result has been taken. Each byte causes one
  // result, so a short settle afterwards is enough before any register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the three sync word registers back to back, optionally followed by
  // a write to the unused index with inverted data.
  task automatic program_sync(input sync_cfg_t word, input bit poke_unused);
    logic [BYTE_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0] idx[4];
    int n;
    vals = '{word.first, word.second, word.third, ~word.first};
    idx = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_SYNC_THIRD, CFG_UNUSED};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (idx[i])
        CFG_SYNC_FIRST:  sync_word.first = vals[i];
        CFG_SYNC_SECOND: sync_word.second = vals[i];
        CFG_SYNC_THIRD:  sync_word.third = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Directed traffic with the sync word left at its reset value.
  task automatic test_reset_sync_word();
    // Noise at both byte extremes is dropped one by one.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Zero length gives an empty frame.
    send_sync();
    send_byte(8'h00);
    // Broken second byte that is plain noise, then one that restarts.
    send_byte(sync_word.first);
    send_byte(8'h00);
    send_byte(sync_word.first);
    send_byte(sync_word.first);
    send_byte(sync_word.second);
    send_byte(sync_word.third);
    send_byte(8'h01);
    send_byte(8'hFF);
    // Broken third byte: a restart on the first sync byte, then plain noise.
    send_byte(sync_word.first);
    send_byte(sync_word.second);
    send_byte(sync_word.first);
    send_byte(sync_word.second);
    send_byte(8'h00);
    // Sync bytes as payload are passed through untouched.
    send_sync();
    send_byte(8'h03);
    send_byte(sync_word.first);
    send_byte(sync_word.second);
    send_byte(sync_word.third);
    wait_idle();
  endtask

  // Directed traffic after sync word writes, including equal first and second
  // bytes, byte extremes, and a write to the unused index.
  task automatic test_sync_word_config();
    program_sync('{first: 8'hAA, second: 8'hAA, third: 8'h55}, 1'b1);
    // Third position repeats the first byte: the match slides by one.
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'h7E);
    // Third position fails on noise: all three are dropped.
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h00);
    wait_idle();
    program_sync('{first: 8'h00, second: 8'hFF, third: 8'h00}, 1'b0);
    send_sync();
    send_byte(8'h00);
    send_sync();
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
  endtask

  function automatic logic [BYTE_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 8'h00;
    if (roll < 85) return 8'($urandom_range(1, 6));
    if (roll < 98) return 8'($urandom_range(7, 40));
    return 8'hFF;
  endfunction

  // Payload bytes sometimes copy a sync byte to show they are not matched.
  function automatic logic [BYTE_W-1:0] pick_payload();
    case ($urandom_range(0, 19))
      0: return sync_word.first;
      1: return sync_word.second;
      2: return sync_word.third;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input logic [BYTE_W-1:0] len);
    send_sync();
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(pick_payload());
    random_sent += 4 + len;
  endtask

  // Random traffic over several sync words. Most of it is well-formed frames
  // with random content; the rest is broken syncs and line noise.
  task automatic test_random_frames();
    sync_cfg_t word;
    logic [BYTE_W-1:0] same;
    int roll;
    int quota;
    for (int s = 0; s < SETTING_COUNT; s++) begin
      same = 8'($urandom_range(0, 255));
      case (s)
        0: word = '{first: SYNC_FIRST_RST, second: SYNC_SECOND_RST, third: SYNC_THIRD_RST};
        1: word = '{first: 8'h00, second: 8'h00, third: 8'h00};
        2: word = '{first: 8'hFF, second: 8'hFF, third: 8'hFF};
        3: word = '{first: same, second: same, third: 8'($urandom_range(0, 255))};
        4: word = '{first: same, second: same, third: same};
        default: word = 24'($urandom);
      endcase
      program_sync(word, 1'b0);
      steady = (s % 3 == 2);
      quota = random_sent + RANDOM_BYTES / SETTING_COUNT;
      // One frame of the largest length in one of the settings.
      if (s == 5) send_frame(8'hFF);
      while (random_sent < quota) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_frame(pick_length());
        end else if (roll < 85) begin
          // A sync start of one or two bytes, then the first sync byte or a random byte.
          send_byte(sync_word.first);
          random_sent++;
          if ($urandom_range(0, 1)) begin
            send_byte(sync_word.second);
            random_sent++;
          end
          send_byte($urandom_range(0, 1) ? sync_word.first : 8'($urandom_range(0, 255)));
          random_sent++;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_byte(8'($urandom_range(0, 255)));
            random_sent++;
          end
        end
      end
      wait_idle();
    end
    steady = 1'b0;
  endtask

  initial begin
    hunt_phase = PH_HUNT;
    frame_left = '0;
    sync_word = '{first: SYNC_FIRST_RST, second: SYNC_SECOND_RST, third: SYNC_THIRD_RST};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sync_word();
    test_sync_word_config();
    test_random_frames();

    wait_idle();
    repeat (8) @(posedge clk);
    if (deframed_q.size() != 0) flag_mismatch("results never delivered", 0, deframed_q.size());
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
